### design/segment_tree_range_sum_assert.svh
// ----------------------------------------------------------------------------
// segment_tree_range_sum_assert.svh
// assertion macros shared by the segment tree blocks; each macro expects
// clk and arst_n in scope
// ----------------------------------------------------------------------------
`ifndef SEGMENT_TREE_RANGE_SUM_ASSERT_SVH
`define SEGMENT_TREE_RANGE_SUM_ASSERT_SVH

// condition holds at every clock edge outside reset
`define SEGSUM_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SEGSUM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define SEGSUM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/segsum_pkg.sv
// ----------------------------------------------------------------------------
// segsum_pkg
// widths, defaults and controller/datapath command and status types for the
// segment tree range sum block
// ----------------------------------------------------------------------------
`default_nettype none

package segsum_pkg;

	localparam int SEGSUM_POS_W        = 11;
	localparam int SEGSUM_VALUE_W      = 32;
	localparam int SEGSUM_SUM_W        = 42;
	localparam int SEGSUM_LEAVES_DEF   = 1024;

	// controller to datapath commands
	typedef struct packed {
		logic load_item;  // latch the incoming request
		logic prep;       // form node bounds and leaf index
		logic q_lread;    // read node at left bound
		logic q_ladd;     // accumulate left node, step left bound
		logic q_rread;    // step right bound down and read it
		logic q_radd;     // accumulate right node
		logic q_shift;    // move both bounds up one level
		logic u_lread;    // read old leaf value
		logic u_leaf;     // write new leaf, form difference, read parent
		logic u_walk;     // write ancestor, read next ancestor
		logic clr_step;   // clear one node
		logic out_load;   // capture sum into output register
	} segsum_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic func;         // request asks for a sum
		logic pos_ok;       // position lies inside the leaves
		logic l_lt_r;       // query window not yet empty
		logic l_odd;        // left bound is a right child
		logic r_odd;        // right bound is a right child
		logic parent_zero;  // current update node is the root
		logic clr_last;     // clearing pass at its last node
	} segsum_sts_t;

endpackage

`default_nettype wire

### design/segsum_if.sv
// ----------------------------------------------------------------------------
// segsum_in_if / segsum_out_if
// valid/ready channels carrying requests into and sums out of the block
// ----------------------------------------------------------------------------
`default_nettype none

interface segsum_in_if import segsum_pkg::*; ();
	logic                             valid;
	logic                             ready;
	logic                             func;
	logic [SEGSUM_POS_W-1:0]          range_first;
	logic [SEGSUM_POS_W-1:0]          range_second;
	logic [SEGSUM_POS_W-1:0]          position;
	logic signed [SEGSUM_VALUE_W-1:0] new_value;

	modport source (
		output valid, func, range_first, range_second, position, new_value,
		input  ready
	);
	modport sink (
		input  valid, func, range_first, range_second, position, new_value,
		output ready
	);
endinterface

interface segsum_out_if import segsum_pkg::*; ();
	logic                           valid;
	logic                           ready;
	logic signed [SEGSUM_SUM_W-1:0] range_sum;

	modport source (output valid, range_sum, input ready);
	modport sink   (input valid, range_sum, output ready);
endinterface

`default_nettype wire

### design/segment_tree_range_sum.sv
// ----------------------------------------------------------------------------
// segment_tree_range_sum
// sum segment tree over LEAVES signed values with point replacement and
// inclusive range sum requests
// ----------------------------------------------------------------------------
// Requests come in on item (valid/ready). func 0 replaces the value at
// position; func 1 first returns the sum over range_first..range_second
// (either order, clamped to 1..LEAVES) on result, then replaces the value.
// A position outside 1..LEAVES replaces nothing. Requests are handled one
// at a time; item.ready is high only while the sequencer is idle. The node
// memory has one read and one write port: a query makes up to two node
// reads per tree level through the registered read port; a replacement
// reads the old leaf, writes the new one and then writes each ancestor up
// to the root. The sum sits in an output register; a stalled receiver only
// holds the block when the next sum is ready to hand over, and a new
// request is still taken while a sum waits. After reset the block clears
// all 2*LEAVES nodes, one per cycle, before item.ready first rises.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_tree_range_sum import segsum_pkg::*; #(
	parameter int LEAVES = SEGSUM_LEAVES_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	segsum_in_if.sink     item,
	segsum_out_if.source  result
);

	segsum_cmd_t cmd;
	segsum_sts_t sts;

	segsum_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	segsum_dp #(
		.LEAVES (LEAVES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (item.func),
		.range_first  (item.range_first),
		.range_second (item.range_second),
		.position     (item.position),
		.new_value    (item.new_value),
		.range_sum    (result.range_sum)
	);

endmodule

`default_nettype wire

### design/segsum_ram.sv
// ----------------------------------------------------------------------------
// segsum_ram
// generic simple dual port ram, one write and one read port, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module segsum_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### design/segsum_ctrl.sv
// ----------------------------------------------------------------------------
// segsum_ctrl
// sequencer for the segment tree: clearing pass, query level walk, output
// handoff and leaf-to-root update walk
// ----------------------------------------------------------------------------
`default_nettype none
`include "segment_tree_range_sum_assert.svh"

module segsum_ctrl import segsum_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	input  wire segsum_sts_t sts,
	output segsum_cmd_t cmd
);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_PREP = 4'd2;
	localparam logic [3:0] S_QL   = 4'd3;
	localparam logic [3:0] S_QLW  = 4'd4;
	localparam logic [3:0] S_QR   = 4'd5;
	localparam logic [3:0] S_QRW  = 4'd6;
	localparam logic [3:0] S_OUT  = 4'd7;
	localparam logic [3:0] S_U0   = 4'd8;
	localparam logic [3:0] S_U1   = 4'd9;
	localparam logic [3:0] S_UW   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = sts.func ? S_QL : S_U0;
			end
			S_QL: begin
				if (!sts.l_lt_r) begin
					state_d = S_OUT;
				end else if (sts.l_odd) begin
					cmd.q_lread = 1'b1;
					state_d     = S_QLW;
				end else begin
					state_d = S_QR;
				end
			end
			S_QLW: begin
				cmd.q_ladd = 1'b1;
				state_d    = S_QR;
			end
			S_QR: begin
				if (sts.r_odd) begin
					cmd.q_rread = 1'b1;
					state_d     = S_QRW;
				end else begin
					cmd.q_shift = 1'b1;
					state_d     = S_QL;
				end
			end
			S_QRW: begin
				cmd.q_radd  = 1'b1;
				cmd.q_shift = 1'b1;
				state_d     = S_QL;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_U0;
				end
			end
			S_U0: begin
				if (sts.pos_ok) begin
					cmd.u_lread = 1'b1;
					state_d     = S_U1;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_U1: begin
				cmd.u_leaf = 1'b1;
				state_d    = S_UW;
			end
			S_UW: begin
				cmd.u_walk = 1'b1;
				if (sts.parent_zero) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register, clearing pass starts at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	`SEGSUM_ASSERT_NEXT(a_accept_to_prep, in_valid && in_ready, state_q == S_PREP, "no start")
	`SEGSUM_ASSERT_SAME(a_rose_after_out, $rose(out_valid_q), $past(state_q) == S_OUT, "stray sum")
	`SEGSUM_ASSERT_ALWAYS(a_one_writer, $onehot0({cmd.clr_step, cmd.u_leaf, cmd.u_walk}), "ram clash")
	`SEGSUM_ASSERT_NEXT(a_clear_done, (state_q == S_CLR) && sts.clr_last, state_q == S_IDLE, "clear overran")

endmodule

`default_nettype wire

### design/segsum_dp.sv
// ----------------------------------------------------------------------------
// segsum_dp
// segment tree datapath: node memory, query bounds and accumulator, update
// walk with difference register, clear counter and output register
// ----------------------------------------------------------------------------
`default_nettype none

module segsum_dp import segsum_pkg::*; #(
	parameter int LEAVES = SEGSUM_LEAVES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire segsum_cmd_t                     cmd,
	output segsum_sts_t                          sts,
	input  wire logic                            func,
	input  wire logic [SEGSUM_POS_W-1:0]         range_first,
	input  wire logic [SEGSUM_POS_W-1:0]         range_second,
	input  wire logic [SEGSUM_POS_W-1:0]         position,
	input  wire logic signed [SEGSUM_VALUE_W-1:0] new_value,
	output logic signed [SEGSUM_SUM_W-1:0]       range_sum
);

	localparam int NODES  = 2 * LEAVES;
	localparam int NODE_W = $clog2(NODES);
	localparam int IDX_W  = NODE_W + 1;
	localparam int CMP_W  = (NODE_W > SEGSUM_POS_W) ? NODE_W : SEGSUM_POS_W;
	localparam int EXT_W  = ((IDX_W > CMP_W) ? IDX_W : CMP_W) + 1;
	localparam int SGN_W  = SEGSUM_SUM_W - SEGSUM_VALUE_W;

	localparam logic [CMP_W-1:0]  LEAVES_C = CMP_W'(LEAVES);
	localparam logic [NODE_W-1:0] LAST_C   = NODE_W'(NODES - 1);

	// latched request
	logic                    func_q;
	logic [SEGSUM_POS_W-1:0] first_q;
	logic [SEGSUM_POS_W-1:0] second_q;
	logic [SEGSUM_POS_W-1:0] pos_q;
	logic [SEGSUM_SUM_W-1:0] value_q;

	// walk state
	logic [IDX_W-1:0]        l_q;
	logic [IDX_W-1:0]        r_q;
	logic [SEGSUM_SUM_W-1:0] sum_q;
	logic [NODE_W-1:0]       node_q;
	logic                    pos_ok_q;
	logic [SEGSUM_SUM_W-1:0] diff_q;
	logic [NODE_W-1:0]       clr_q;
	logic [SEGSUM_SUM_W-1:0] range_sum_q;

	// ram ports
	logic                    we;
	logic [NODE_W-1:0]       waddr;
	logic [SEGSUM_SUM_W-1:0] wdata;
	logic [NODE_W-1:0]       raddr;
	logic [SEGSUM_SUM_W-1:0] rdata;

	// bound preparation
	logic [CMP_W-1:0] a_x;
	logic [CMP_W-1:0] b_x;
	logic [CMP_W-1:0] lo;
	logic [CMP_W-1:0] hi;
	logic [CMP_W-1:0] lo_c;
	logic [CMP_W-1:0] hi_c;
	logic [CMP_W-1:0] pos_x;
	logic             empty;
	logic [EXT_W-1:0] l_ext;
	logic [EXT_W-1:0] r_ext;
	logic [EXT_W-1:0] node_ext;
	logic [IDX_W-1:0] r_dec;
	logic [NODE_W-1:0] parent;

	// order and clamp the range, map it onto leaf node indexes
	always_comb begin
		a_x      = CMP_W'(first_q);
		b_x      = CMP_W'(second_q);
		lo       = (a_x < b_x) ? a_x : b_x;
		hi       = (a_x < b_x) ? b_x : a_x;
		lo_c     = (lo == '0) ? CMP_W'(1) : lo;
		hi_c     = (hi > LEAVES_C) ? LEAVES_C : hi;
		empty    = (lo_c > hi_c);
		l_ext    = EXT_W'(LEAVES_C) + EXT_W'(lo_c) - EXT_W'(1);
		r_ext    = EXT_W'(LEAVES_C) + EXT_W'(hi_c);
		pos_x    = CMP_W'(pos_q);
		node_ext = EXT_W'(LEAVES_C) + EXT_W'(pos_x) - EXT_W'(1);
	end

	assign r_dec  = r_q - IDX_W'(1);
	assign parent = node_q >> 1;

	// status to controller
	always_comb begin
		sts.func        = func_q;
		sts.pos_ok      = pos_ok_q;
		sts.l_lt_r      = (l_q < r_q);
		sts.l_odd       = l_q[0];
		sts.r_odd       = r_q[0];
		sts.parent_zero = (parent == '0);
		sts.clr_last    = (clr_q == LAST_C);
	end

	// ram address and data selection
	always_comb begin
		priority if (cmd.q_lread) begin
			raddr = l_q[NODE_W-1:0];
		end else if (cmd.q_rread) begin
			raddr = r_dec[NODE_W-1:0];
		end else if (cmd.u_lread) begin
			raddr = node_q;
		end else begin
			raddr = parent;
		end
		we    = cmd.clr_step | cmd.u_leaf | cmd.u_walk;
		waddr = cmd.clr_step ? clr_q : node_q;
		priority if (cmd.clr_step) begin
			wdata = '0;
		end else if (cmd.u_leaf) begin
			wdata = value_q;
		end else begin
			wdata = rdata + diff_q;
		end
	end

	segsum_ram #(
		.WIDTH (SEGSUM_SUM_W),
		.DEPTH (NODES)
	) u_nodes (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			func_q   <= func;
			first_q  <= range_first;
			second_q <= range_second;
			pos_q    <= position;
			value_q  <= {{SGN_W{new_value[SEGSUM_VALUE_W-1]}}, new_value};
		end
	end

	// query bounds and accumulator
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			l_q   <= empty ? '0 : l_ext[IDX_W-1:0];
			r_q   <= empty ? '0 : r_ext[IDX_W-1:0];
			sum_q <= '0;
		end else begin
			if (cmd.q_ladd) begin
				sum_q <= sum_q + rdata;
				l_q   <= l_q + IDX_W'(1);
			end
			if (cmd.q_rread) begin
				r_q <= r_dec;
			end
			if (cmd.q_radd) begin
				sum_q <= sum_q + rdata;
			end
			if (cmd.q_shift) begin
				l_q <= l_q >> 1;
				r_q <= r_q >> 1;
			end
		end
	end

	// update walk
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			pos_ok_q <= (pos_x != '0) && (pos_x <= LEAVES_C);
			node_q   <= node_ext[NODE_W-1:0];
		end else if (cmd.u_leaf) begin
			diff_q <= value_q - rdata;
			node_q <= parent;
		end else if (cmd.u_walk) begin
			node_q <= parent;
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + NODE_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			range_sum_q <= sum_q;
		end
	end

	assign range_sum = range_sum_q;

endmodule

`default_nettype wire

### tb/segment_tree_range_sum_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_tree_range_sum_tb
// Drives load and sum requests into the range sum tree and checks every
// returned sum against a leaf-level software copy of the tree contents.
// A short directed list covers value extremes, reversed and clipped ranges,
// empty ranges and positions outside the leaves. A long random run follows,
// with bursty requests and a receiver that stalls in changing patterns.
// ----------------------------------------------------------------------------

module segment_tree_range_sum_tb;
	import segsum_pkg::*;

	localparam int LEAVES          = SEGSUM_LEAVES_DEF;
	localparam int RANDOM_REQUESTS = 950;
	localparam int DRAIN_CYCLES    = 80;

	typedef enum logic {FUNC_LOAD = 1'b0, FUNC_QUERY = 1'b1} func_e;
	typedef enum int {RECV_STEADY, RECV_COIN, RECV_SPARSE, RECV_LONG} recv_mode_e;

	typedef struct packed {
		func_e                            func;
		logic [SEGSUM_POS_W-1:0]          range_first;
		logic [SEGSUM_POS_W-1:0]          range_second;
		logic [SEGSUM_POS_W-1:0]          position;
		logic signed [SEGSUM_VALUE_W-1:0] new_value;
	} request_t;

	logic clk;
	logic arst_n;

	segsum_in_if  item_bus ();
	segsum_out_if result_bus ();

	segment_tree_range_sum #(.LEAVES(LEAVES)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus)
	);

	// leaf values of the tree as the block should hold them
	logic signed [SEGSUM_VALUE_W-1:0] leaf_value [1:LEAVES];
	logic signed [SEGSUM_SUM_W-1:0]   expected_sums [$];
	request_t                         pending [$];
	request_t                         in_flight;

	int accepted_count = 0;
	int mismatch_count = 0;
	int burst_left;
	int gap_left;
	int mode_left;
	int tick;
	recv_mode_e recv_mode;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// sum over the clipped range first, then replace the leaf
	function automatic void sum_then_store(request_t req);
		int lo;
		int hi;
		logic signed [SEGSUM_SUM_W-1:0] acc;
		if (req.func == FUNC_QUERY) begin
			lo = (req.range_first < req.range_second) ? req.range_first : req.range_second;
			hi = (req.range_first < req.range_second) ? req.range_second : req.range_first;
			if (lo < 1)
				lo = 1;
			if (hi > LEAVES)
				hi = LEAVES;
			acc = '0;
			for (int p = lo; p <= hi; p++)
				acc += {{(SEGSUM_SUM_W-SEGSUM_VALUE_W){leaf_value[p][SEGSUM_VALUE_W-1]}},
					leaf_value[p]};
			expected_sums.push_back(acc);
		end
		if (req.position >= 1 && req.position <= LEAVES)
			leaf_value[req.position] = req.new_value;
	endfunction

	function automatic void flag_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] %s", $time, msg);
	endfunction

	function automatic void queue_request(func_e func, int first, int second, int pos,
		logic [SEGSUM_VALUE_W-1:0] value);
		request_t req;
		req.func         = func;
		req.range_first  = SEGSUM_POS_W'(first);
		req.range_second = SEGSUM_POS_W'(second);
		req.position     = SEGSUM_POS_W'(pos);
		req.new_value    = value;
		pending.push_back(req);
	endfunction

	// mostly inside the current window, now and then anywhere the field allows
	function automatic int pick_index(int lo, int hi);
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(0, (1 << SEGSUM_POS_W) - 1);
		return $urandom_range(lo, hi);
	endfunction

	// request driver: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_bus.valid        <= 1'b0;
			item_bus.func         <= FUNC_LOAD;
			item_bus.range_first  <= '0;
			item_bus.range_second <= '0;
			item_bus.position     <= '0;
			item_bus.new_value    <= '0;
			burst_left = 0;
			gap_left   = 0;
			foreach (leaf_value[p])
				leaf_value[p] = '0;
		end else begin
			if (item_bus.valid && item_bus.ready) begin
				sum_then_store(in_flight);
				accepted_count++;
			end
			// channel free: idle out a gap or present the next request
			if (!item_bus.valid || item_bus.ready) begin
				if (gap_left > 0 || pending.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					item_bus.valid <= 1'b0;
				end else begin
					in_flight = pending.pop_front();
					item_bus.valid        <= 1'b1;
					item_bus.func         <= in_flight.func;
					item_bus.range_first  <= in_flight.range_first;
					item_bus.range_second <= in_flight.range_second;
					item_bus.position     <= in_flight.position;
					item_bus.new_value    <= in_flight.new_value;
					if (burst_left == 0)
						burst_left = $urandom_range(1, 24);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 60)
							: $urandom_range(0, 3);
				end
			end
		end
	end

	// sum monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
			recv_mode = RECV_STEADY;
			mode_left = 0;
			tick      = 0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				if (expected_sums.size() == 0)
					flag_mismatch($sformatf("unexpected range_sum %0d", result_bus.range_sum));
				else if (result_bus.range_sum !== expected_sums[0])
					flag_mismatch($sformatf("range_sum expected %0d got %0d",
						expected_sums[0], result_bus.range_sum));
				if (expected_sums.size() != 0)
					void'(expected_sums.pop_front());
			end
			if (mode_left == 0) begin
				recv_mode = recv_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 600);
			end
			mode_left--;
			tick++;
			case (recv_mode)
				RECV_STEADY: result_bus.ready <= 1'b1;
				RECV_COIN:   result_bus.ready <= 1'($urandom_range(0, 1));
				RECV_SPARSE: result_bus.ready <= (tick % 5 == 0);
				default:     result_bus.ready <= (tick % 48 >= 40);
			endcase
		end
	end

	// stimulus, reset and end of run
	initial begin
		int win_lo;
		int win_hi;
		int total;
		logic [SEGSUM_VALUE_W-1:0] value;

		arst_n <= 1'b0;

		// directed: extremes, reversed and clipped ranges, ignored positions
		queue_request(FUNC_LOAD,  1,    1,    1,    32'h7FFF_FFFF);
		queue_request(FUNC_LOAD,  1,    1,    1024, 32'h8000_0000);
		queue_request(FUNC_QUERY, 1,    1024, 512,  32'h0000_0001);
		queue_request(FUNC_QUERY, 1024, 1,    2,    32'hFFFF_FFFF);
		queue_request(FUNC_QUERY, 1,    1,    0,    32'h0000_007B);
		queue_request(FUNC_QUERY, 1024, 1024, 2047, 32'h0000_0005);
		queue_request(FUNC_QUERY, 0,    2047, 1025, 32'h0000_0007);
		queue_request(FUNC_QUERY, 0,    0,    3,    32'h0000_0000);
		queue_request(FUNC_QUERY, 1500, 2047, 1023, 32'h5555_5555);
		queue_request(FUNC_QUERY, 1025, 1,    1022, 32'h7FFF_FFFF);
		queue_request(FUNC_QUERY, 512,  512,  512,  32'hAAAA_AAAA);
		queue_request(FUNC_QUERY, 512,  512,  4,    32'h8000_0000);
		queue_request(FUNC_LOAD,  0,    2047, 1021, 32'h7FFF_FFFF);
		queue_request(FUNC_LOAD,  2047, 0,    1020, 32'h7FFF_FFFF);
		queue_request(FUNC_QUERY, 1020, 1024, 1,    32'h0000_0000);
		queue_request(FUNC_QUERY, 1024, 1020, 1024, 32'h0000_0000);
		queue_request(FUNC_QUERY, 2,    1023, 5,    32'h8000_0001);
		queue_request(FUNC_QUERY, 1,    2,    6,    32'h0000_0000);
		queue_request(FUNC_QUERY, 1024, 1025, 1024, 32'h0000_0000);
		queue_request(FUNC_QUERY, 0,    1,    2047, 32'hFFFF_FFFF);
		queue_request(FUNC_QUERY, 1,    1024, 1,    32'h0000_0000);

		// random: ranges and positions mostly inside a shifting window
		win_lo = 1;
		win_hi = LEAVES;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 40 == 0) begin
				if ($urandom_range(0, 1)) begin
					win_lo = 1;
					win_hi = LEAVES;
				end else begin
					win_lo = $urandom_range(1, LEAVES - 63);
					win_hi = win_lo + $urandom_range(0, 63);
				end
			end
			case ($urandom_range(0, 7))
				0:       value = 32'h7FFF_FFFF;
				1:       value = 32'h8000_0000;
				2:       value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
				3:       value = 32'($urandom_range(0, 200)) - 32'd100;
				default: value = $urandom();
			endcase
			queue_request(func_e'($urandom_range(0, 1)), pick_index(win_lo, win_hi),
				pick_index(win_lo, win_hi), pick_index(win_lo, win_hi), value);
		end
		total = pending.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count < total)
			@(posedge clk);
		while (expected_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		mismatch_count += expected_sums.size();
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
